>>> hdl/pba_pkg.sv
// shared types and constants for the page block allocator
package pba_pkg;

  localparam int unsigned PAGE_HEADER = 8;

  // descriptor modes
  localparam logic MODE_MULTI  = 1'b0;
  localparam logic MODE_BLOCKS = 1'b1;

  // request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_NOT_ALLOC = 2'd2;

  // controller to datapath commands
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_DIV,
    CMD_SCAN_START,
    CMD_SCAN_READ,
    CMD_SCAN_EVAL,
    CMD_SMALL_COMMIT,
    CMD_FREE_READ,
    CMD_FREE_EVAL,
    CMD_RUN_WRITE,
    CMD_RESULT
  } cmd_t;

  // datapath status back to the controller
  typedef struct packed {
    logic is_free_req;
    logic is_small;
    logic div_done;
    logic scan_done;
    logic found;
    logic free_bad;
    logic free_multi;
    logic run_done;
    logic clear_done;
  } dp_status_t;

endpackage

>>> hdl/pba_if.sv
// valid/ready channel interfaces for requests and results
interface pba_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [21:0] request_bytes;
  logic [9:0]  page_index;
  modport source (output valid, kind, request_bytes, page_index, input ready);
  modport sink (input valid, kind, request_bytes, page_index, output ready);
endinterface

interface pba_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [9:0]  result_page;
  logic [9:0]  block_slot;
  logic [11:0] block_offset;
  logic [10:0] pages_taken;
  modport source (output valid, status, result_page, block_slot, block_offset, pages_taken,
                  input ready);
  modport sink (input valid, status, result_page, block_slot, block_offset, pages_taken,
                output ready);
endinterface

>>> hdl/pba_datapath.sv
// descriptor memory, size divider, scan and run update logic
module pba_datapath import pba_pkg::*; #(
  parameter int unsigned NUM_PAGES    = 1024,
  parameter int unsigned PAGE_PAYLOAD = 3992
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  input  logic        kind,
  input  logic [21:0] request_bytes,
  input  logic [9:0]  page_index,
  output dp_status_t  stat,
  output logic [1:0]  status,
  output logic [9:0]  result_page,
  output logic [9:0]  block_slot,
  output logic [11:0] block_offset,
  output logic [10:0] pages_taken
);

  localparam int unsigned AW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int unsigned CW = AW + 1;           // counts up to NUM_PAGES
  localparam int unsigned SW = 23;               // size field, bytes or pages
  localparam int unsigned DW = 2 + SW + SW;      // free, mode, size, count
  localparam int unsigned HALF = PAGE_PAYLOAD / 2;
  // reciprocal of the page payload, exact for every SW-bit size
  localparam int unsigned PL = $clog2(PAGE_PAYLOAD);
  localparam logic [SW:0] RECIP = (SW+1)'(((64'd1 << (SW + PL)) + 64'(PAGE_PAYLOAD) - 64'd1) /
                                          64'(PAGE_PAYLOAD));

  typedef struct packed {
    logic          free;
    logic          mode;
    logic [SW-1:0] size;
    logic [SW-1:0] count;
  } desc_t;

  // descriptor memory, one read port and one write port, registered read
  desc_t         mem [NUM_PAGES];
  desc_t         rd_r;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  desc_t         wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
  end

  // request registers
  logic          kind_r;
  logic [SW-1:0] sz_r;
  logic          small_r;
  logic [21:0]   pidx_r;
  logic [SW-1:0] cap_r;
  logic [SW-1:0] npg_r;

  // restoring divider for the block capacity, one bit per cycle
  logic [SW-1:0] dq_r, drem_r, dden_r;
  logic [4:0]    dcnt_r;
  logic          dbusy_r;

  // scan state
  logic [CW-1:0] idx_r;
  logic [CW-1:0] run_r;
  logic [CW-1:0] ff_r;
  logic          hit_r;
  logic [AW-1:0] hit_idx_r;
  desc_t         hit_d_r;
  logic          found_r;
  logic [AW-1:0] start_r;

  // run rewrite / release
  logic [CW-1:0] wi_r, wend_r;
  logic          wfree_r;
  logic [SW-1:0] wcnt_r;

  // clearing pass after reset
  logic          clr_r;
  logic [CW-1:0] clr_idx_r;

  // result registers
  logic [1:0]  st_r;
  logic [9:0]  pg_r;
  logic [9:0]  slot_r;
  logic [11:0] off_r;
  logic [10:0] pt_r;

  // rounded size
  logic [SW-1:0] sz_in;
  always_comb begin
    sz_in = ({1'b0, request_bytes} + SW'(3)) & ~SW'(3);
    if (sz_in == '0) sz_in = SW'(4);
  end

  // large request: size / payload by reciprocal multiplication
  logic [2*SW:0] lq_prod;
  logic [SW-1:0] lq;
  assign lq_prod = {{(SW+1){1'b0}}, sz_in} * {{SW{1'b0}}, RECIP};
  assign lq      = SW'(lq_prod >> (SW + PL));

  // scan evaluation on the descriptor read last cycle
  logic          cur_small_hit;
  logic [CW-1:0] run_inc;
  always_comb begin
    cur_small_hit = !rd_r.free && rd_r.mode == MODE_BLOCKS && rd_r.size == sz_r &&
                    rd_r.count < cap_r;
    run_inc = rd_r.free ? run_r + CW'(1) : '0;
  end

  // free run bounds
  logic [SW-1:0] f_start;
  logic [SW:0]   f_end;
  always_comb begin
    f_start = (rd_r.count <= SW'(pidx_r)) ? SW'(pidx_r) - rd_r.count : '0;
    f_end   = {1'b0, f_start} + {1'b0, rd_r.size};
    if (f_end > (SW+1)'(NUM_PAGES)) f_end = (SW+1)'(NUM_PAGES);
    if (f_end <= (SW+1)'(pidx_r)) f_end = (SW+1)'(pidx_r) + (SW+1)'(1);
  end

  // slot offset product
  logic [SW+SW-1:0] prod;
  assign prod = hit_d_r.count * sz_r;

  // a released run page keeps nothing but its free flag
  function automatic desc_t mem_keep_free();
    desc_t d;
    d = '{free: 1'b1, mode: MODE_MULTI, size: '0, count: '0};
    return d;
  endfunction

  // memory port muxing
  always_comb begin
    raddr = idx_r[AW-1:0];
    if (cmd == CMD_FREE_READ) raddr = pidx_r[AW-1:0];
    we    = 1'b0;
    waddr = wi_r[AW-1:0];
    wdata = '{free: wfree_r, mode: MODE_MULTI, size: npg_r, count: wcnt_r};
    if (clr_r) begin
      we    = 1'b1;
      waddr = clr_idx_r[AW-1:0];
      wdata = '{free: 1'b1, mode: MODE_MULTI, size: '0, count: '0};
    end else if (cmd == CMD_SMALL_COMMIT) begin
      we    = 1'b1;
      waddr = hit_idx_r;
      if (hit_r) begin
        wdata = hit_d_r;
      end else begin
        wdata = '{free: 1'b0, mode: MODE_BLOCKS, size: sz_r, count: '0};
      end
      wdata.count = (hit_r ? hit_d_r.count : '0) + SW'(1);
    end else if (cmd == CMD_FREE_EVAL) begin
      we    = !rd_r.free && pidx_r < 22'(NUM_PAGES) && rd_r.mode == MODE_BLOCKS;
      waddr = pidx_r[AW-1:0];
      wdata = rd_r;
      if (rd_r.count > SW'(1)) wdata.count = rd_r.count - SW'(1);
      else wdata.free = 1'b1;
    end else if (cmd == CMD_RUN_WRITE) begin
      we = 1'b1;
      if (wfree_r) wdata = mem_keep_free();
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
      dbusy_r   <= 1'b0;
    end else begin
      // clearing pass
      if (clr_r) begin
        clr_idx_r <= clr_idx_r + CW'(1);
        if (clr_idx_r == CW'(NUM_PAGES - 1)) clr_r <= 1'b0;
      end
      unique case (cmd)
        CMD_LOAD: begin
          kind_r  <= kind;
          pidx_r  <= {12'd0, page_index};
          sz_r    <= sz_in;
          small_r <= sz_in <= SW'(HALF);
          drem_r  <= '0;
          dcnt_r  <= 5'(SW);
          dden_r  <= sz_in;
          dbusy_r <= !kind && sz_in <= SW'(HALF);
          // small: cap = PAYLOAD / sz by the divider; large: sz / PAYLOAD right away
          if (sz_in <= SW'(HALF)) begin
            dq_r <= SW'(PAGE_PAYLOAD);
          end else begin
            dq_r <= lq;
          end
        end
        CMD_DIV: begin
          if (dbusy_r) begin
            logic [SW:0] t;
            t = {drem_r, dq_r[SW-1]};
            if (t >= {1'b0, dden_r}) begin
              drem_r <= SW'(t - {1'b0, dden_r});
              dq_r   <= {dq_r[SW-2:0], 1'b1};
            end else begin
              drem_r <= t[SW-1:0];
              dq_r   <= {dq_r[SW-2:0], 1'b0};
            end
            dcnt_r <= dcnt_r - 5'd1;
            if (dcnt_r == 5'd1) dbusy_r <= 1'b0;
          end
        end
        CMD_SCAN_START: begin
          cap_r   <= dq_r;
          npg_r   <= dq_r + SW'(1);
          idx_r   <= '0;
          run_r   <= '0;
          ff_r    <= CW'(NUM_PAGES);
          hit_r   <= 1'b0;
          found_r <= 1'b0;
        end
        CMD_SCAN_EVAL: begin
          idx_r <= idx_r + CW'(1);
          if (small_r) begin
            if (rd_r.free && ff_r == CW'(NUM_PAGES)) ff_r <= idx_r;
            if (cur_small_hit) begin
              hit_r     <= 1'b1;
              found_r   <= 1'b1;
              hit_idx_r <= idx_r[AW-1:0];
              hit_d_r   <= rd_r;
            end
          end else begin
            run_r <= run_inc;
            if (npg_r <= SW'(NUM_PAGES) && SW'(run_inc) >= npg_r) begin
              found_r <= 1'b1;
              start_r <= AW'(SW'(idx_r) + SW'(1) - npg_r);
              wi_r    <= CW'(SW'(idx_r) + SW'(1) - npg_r);
              wend_r  <= idx_r + CW'(1);
              wfree_r <= 1'b0;
              wcnt_r  <= '0;
            end
          end
          // small scan finished without a hit: fall back to the first free page
          if (small_r && !cur_small_hit && idx_r == CW'(NUM_PAGES - 1)) begin
            if (rd_r.free && ff_r == CW'(NUM_PAGES)) begin
              found_r   <= 1'b1;
              hit_idx_r <= idx_r[AW-1:0];
            end else if (ff_r != CW'(NUM_PAGES)) begin
              found_r   <= 1'b1;
              hit_idx_r <= ff_r[AW-1:0];
            end
          end
        end
        CMD_SMALL_COMMIT: begin
          st_r   <= ST_OK;
          pg_r   <= 10'(hit_idx_r);
          slot_r <= hit_r ? hit_d_r.count[9:0] : 10'd0;
          off_r  <= hit_r ? 12'(prod + (SW+SW)'(PAGE_HEADER)) : 12'(PAGE_HEADER);
          pt_r   <= '0;
        end
        CMD_FREE_EVAL: begin
          st_r   <= (pidx_r >= 22'(NUM_PAGES) || rd_r.free) ? ST_NOT_ALLOC : ST_OK;
          pg_r   <= pidx_r[9:0];
          slot_r <= '0;
          off_r  <= '0;
          pt_r   <= '0;
          wi_r    <= CW'(f_start);
          wend_r  <= CW'(f_end);
          wfree_r <= 1'b1;
        end
        CMD_RUN_WRITE: begin
          wi_r   <= wi_r + CW'(1);
          wcnt_r <= wcnt_r + SW'(1);
          if (!kind_r) begin
            st_r   <= ST_OK;
            pg_r   <= 10'(start_r);
            slot_r <= '0;
            off_r  <= 12'(PAGE_HEADER);
            pt_r   <= 11'(npg_r);
          end
        end
        CMD_RESULT: begin
          if (!found_r && !kind_r) begin
            st_r <= ST_NO_SPACE; pg_r <= '0; slot_r <= '0; off_r <= '0; pt_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    stat.is_free_req = kind_r;
    stat.is_small    = small_r;
    stat.div_done    = !dbusy_r;
    stat.scan_done   = idx_r == CW'(NUM_PAGES - 1) || (small_r && cur_small_hit) ||
                       (!small_r && npg_r <= SW'(NUM_PAGES) && SW'(run_inc) >= npg_r) ||
                       (!small_r && npg_r > SW'(NUM_PAGES));
    stat.found       = found_r;
    stat.free_bad    = pidx_r >= 22'(NUM_PAGES) || rd_r.free;
    stat.free_multi  = rd_r.mode == MODE_MULTI;
    stat.run_done    = wi_r + CW'(1) >= wend_r;
    stat.clear_done  = !clr_r;
  end

  assign status       = st_r;
  assign result_page  = pg_r;
  assign block_slot   = slot_r;
  assign block_offset = off_r;
  assign pages_taken  = pt_r;

endmodule

>>> hdl/pba_ctrl.sv
// sequencing state machine for the page block allocator
module pba_ctrl import pba_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t stat,
  output cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_START, S_READ, S_EVAL, S_COMMIT, S_FREAD, S_FEVAL, S_RUN,
    S_RESULT, S_OUT
  } state_t;

  state_t state_r;
  logic   valid_r;

  assign in_ready  = state_r == S_IDLE && stat.clear_done;
  assign out_valid = valid_r;

  // command for the current state
  always_comb begin
    unique case (state_r)
      S_IDLE:   cmd = (in_valid && stat.clear_done) ? CMD_LOAD : CMD_NONE;
      S_DIV:    cmd = CMD_DIV;
      S_START:  cmd = CMD_SCAN_START;
      S_READ:   cmd = CMD_SCAN_READ;
      S_EVAL:   cmd = CMD_SCAN_EVAL;
      S_COMMIT: cmd = CMD_SMALL_COMMIT;
      S_FREAD:  cmd = CMD_FREE_READ;
      S_FEVAL:  cmd = CMD_FREE_EVAL;
      S_RUN:    cmd = CMD_RUN_WRITE;
      S_RESULT: cmd = CMD_RESULT;
      default:  cmd = CMD_NONE;
    endcase
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_valid && stat.clear_done) state_r <= S_DIV;
        S_DIV: begin
          if (stat.is_free_req) state_r <= S_FREAD;
          else if (stat.div_done) state_r <= S_START;
        end
        S_START: state_r <= S_READ;
        S_READ:  state_r <= S_EVAL;
        S_EVAL:  state_r <= stat.scan_done ? S_COMMIT : S_READ;
        S_COMMIT: begin
          // a found run writes its first page here and the rest in S_RUN
          if (stat.found && !stat.is_small && !stat.run_done) state_r <= S_RUN;
          else state_r <= S_RESULT;
        end
        S_FREAD: state_r <= S_FEVAL;
        S_FEVAL: begin
          if (!stat.free_bad && stat.free_multi) state_r <= S_RUN;
          else begin
            state_r <= S_OUT;
            valid_r <= 1'b1;
          end
        end
        S_RUN: begin
          if (stat.run_done) begin
            state_r <= S_OUT;
            valid_r <= 1'b1;
          end
        end
        S_RESULT: begin
          state_r <= S_OUT;
          valid_r <= 1'b1;
        end
        S_OUT: begin
          if (out_ready) begin
            valid_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/pba_commit.sv
// routes the end of a scan to the small commit or the run rewrite, or drops it when nothing was found
module pba_commit import pba_pkg::*; (
  input  cmd_t       cmd_in,
  input  dp_status_t stat,
  input  logic       small_req,
  output cmd_t       cmd_out
);
  // a finished scan becomes a block commit, a run rewrite or no command when nothing was found
  always_comb begin
    cmd_out = cmd_in;
    if (cmd_in == CMD_SMALL_COMMIT) begin
      if (!stat.found) cmd_out = CMD_NONE;
      else if (!small_req) cmd_out = CMD_RUN_WRITE;
    end
  end
endmodule

>>> hdl/page_block_allocator_unit.sv
// Page block allocator: one request at a time. After reset a clearing pass
// marks every page free before the first request is taken. A block-sized
// allocate first works out its block capacity in the restoring divider, a
// multipage one derives its page count by reciprocal multiplication; either
// then scans the descriptor memory page by page (one read port, registered
// read), and a multipage allocation then rewrites one page of its run per
// cycle. A free reads and updates the descriptor of its page, and a free of a
// multipage run releases the whole run. The result is held until taken.
module page_block_allocator_unit import pba_pkg::*; #(
  parameter int unsigned NUM_PAGES    = 1024,
  parameter int unsigned PAGE_PAYLOAD = 3992
) (
  input  logic      clk,
  input  logic      rst_n,
  pba_req_if.sink   in_req,
  pba_rsp_if.source out_rsp
);

  cmd_t       cmd_c, cmd_d;
  dp_status_t stat;
  logic       small_q;

  pba_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .out_valid(out_rsp.valid),
    .out_ready(out_rsp.ready),
    .stat,
    .cmd      (cmd_c)
  );

  // small requests are at most half a page payload
  assign small_q = stat.is_small;

  pba_commit u_commit (
    .cmd_in (cmd_c),
    .stat,
    .small_req(small_q),
    .cmd_out(cmd_d)
  );

  pba_datapath #(.NUM_PAGES(NUM_PAGES), .PAGE_PAYLOAD(PAGE_PAYLOAD)) u_dp (
    .clk, .rst_n,
    .cmd          (cmd_d),
    .kind         (in_req.kind),
    .request_bytes(in_req.request_bytes),
    .page_index   (in_req.page_index),
    .stat,
    .status       (out_rsp.status),
    .result_page  (out_rsp.result_page),
    .block_slot   (out_rsp.block_slot),
    .block_offset (out_rsp.block_offset),
    .pages_taken  (out_rsp.pages_taken)
  );

endmodule

>>> bench/pba_alloc_checker.sv
// allocation checker: predicts every result from the requests it sees and compares
`timescale 1ns / 1ps

module pba_alloc_checker import pba_pkg::*; #(
  parameter int unsigned NUM_PAGES    = 1024,
  parameter int unsigned PAGE_PAYLOAD = 3992
) (
  input  logic      clk,
  input  logic      rst_n,
  pba_req_if        req_mon,
  pba_rsp_if        rsp_mon,
  output int        error_count,
  output int        pending_count
);

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  result_page;
    logic [9:0]  block_slot;
    logic [11:0] block_offset;
    logic [10:0] pages_taken;
  } alloc_result_t;

  // shadow copy of the page descriptors
  logic        page_is_free [NUM_PAGES];
  logic        page_mode    [NUM_PAGES];
  int unsigned page_size    [NUM_PAGES];
  int unsigned page_count   [NUM_PAGES];

  alloc_result_t expected_results[$];

  initial begin
    error_count = 0;
    pending_count = 0;
    for (int i = 0; i < NUM_PAGES; i++) begin
      page_is_free[i] = 1'b1;
      page_mode[i]    = MODE_MULTI;
      page_size[i]    = 0;
      page_count[i]   = 0;
    end
  end

  task report_mismatch(input string what, input int unsigned got, input int unsigned want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // small request: first page of that block size with room, else first free page
  task place_block(input int unsigned bsz, output alloc_result_t r);
    int unsigned cap;
    int unsigned hit;
    int unsigned first_free;
    int unsigned slot;
    cap = PAGE_PAYLOAD / bsz;
    hit = NUM_PAGES;
    first_free = NUM_PAGES;
    r = '0;
    for (int i = 0; i < NUM_PAGES; i++) begin
      if (page_is_free[i]) begin
        if (first_free == NUM_PAGES) first_free = i;
      end else if (page_mode[i] == MODE_BLOCKS && page_size[i] == bsz && page_count[i] < cap) begin
        hit = i;
        break;
      end
    end
    if (hit == NUM_PAGES) begin
      if (first_free == NUM_PAGES) begin
        r.status = ST_NO_SPACE;
        return;
      end
      hit = first_free;
      page_is_free[hit] = 1'b0;
      page_mode[hit]    = MODE_BLOCKS;
      page_size[hit]    = bsz;
      page_count[hit]   = 0;
    end
    slot = page_count[hit];
    page_count[hit] = slot + 1;
    r.status       = ST_OK;
    r.result_page  = hit[9:0];
    r.block_slot   = slot[9:0];
    r.block_offset = 12'(PAGE_HEADER + slot * bsz);
  endtask

  // large request: first run of free pages long enough
  task place_run(input int unsigned npages, output alloc_result_t r);
    int unsigned run_len;
    int unsigned start;
    logic        found;
    run_len = 0;
    start = 0;
    found = 1'b0;
    r = '0;
    if (npages <= NUM_PAGES) begin
      for (int i = 0; i < NUM_PAGES; i++) begin
        run_len = page_is_free[i] ? run_len + 1 : 0;
        if (run_len >= npages) begin
          start = i + 1 - npages;
          found = 1'b1;
          break;
        end
      end
    end
    if (!found) begin
      r.status = ST_NO_SPACE;
      return;
    end
    for (int i = 0; i < npages; i++) begin
      page_is_free[start + i] = 1'b0;
      page_mode[start + i]    = MODE_MULTI;
      page_size[start + i]    = npages;
      page_count[start + i]   = i;
    end
    r.status       = ST_OK;
    r.result_page  = start[9:0];
    r.block_offset = 12'(PAGE_HEADER);
    r.pages_taken  = 11'(npages);
  endtask

  // free one block, or the whole run holding the page
  task release_page(input int unsigned p, output alloc_result_t r);
    int unsigned start;
    int unsigned stop;
    r = '0;
    r.result_page = p[9:0];
    if (p >= NUM_PAGES || page_is_free[p]) begin
      r.status = ST_NOT_ALLOC;
      return;
    end
    if (page_mode[p] == MODE_MULTI) begin
      start = (page_count[p] <= p) ? p - page_count[p] : 0;
      stop = start + page_size[p];
      if (stop > NUM_PAGES || stop < start) stop = NUM_PAGES;
      if (stop <= p) stop = p + 1;
      for (int i = start; i < stop; i++) page_is_free[i] = 1'b1;
    end else if (page_count[p] > 1) begin
      page_count[p] = page_count[p] - 1;
    end else begin
      page_is_free[p] = 1'b1;
    end
    r.status = ST_OK;
  endtask

  task predict_request(input logic kind, input logic [21:0] nbytes, input logic [9:0] page,
                       output alloc_result_t r);
    int unsigned sz;
    if (kind == KIND_FREE) begin
      release_page(page, r);
      return;
    end
    sz = (int'(nbytes) + 3) & ~32'd3;
    if (sz == 0) sz = 4;
    if (sz <= PAGE_PAYLOAD / 2) place_block(sz, r);
    else place_run(sz / PAGE_PAYLOAD + 1, r);
  endtask

  // watch both channels at the rising edge
  always @(posedge clk) begin
    alloc_result_t want;
    if (rst_n) begin
      if (req_mon.valid && req_mon.ready) begin
        predict_request(req_mon.kind, req_mon.request_bytes, req_mon.page_index, want);
        expected_results.push_back(want);
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, status", rsp_mon.status, 0);
        end else begin
          want = expected_results.pop_front();
          if (rsp_mon.status !== want.status)
            report_mismatch("status", rsp_mon.status, want.status);
          if (rsp_mon.result_page !== want.result_page)
            report_mismatch("result_page", rsp_mon.result_page, want.result_page);
          if (rsp_mon.block_slot !== want.block_slot)
            report_mismatch("block_slot", rsp_mon.block_slot, want.block_slot);
          if (rsp_mon.block_offset !== want.block_offset)
            report_mismatch("block_offset", rsp_mon.block_offset, want.block_offset);
          if (rsp_mon.pages_taken !== want.pages_taken)
            report_mismatch("pages_taken", rsp_mon.pages_taken, want.pages_taken);
        end
      end
    end
    pending_count = expected_results.size();
  end

endmodule

>>> bench/tb_top.sv
// testbench top: drives allocate and free requests and gives the verdict
`timescale 1ns / 1ps

module tb_top import pba_pkg::*;;

  localparam int unsigned NUM_PAGES    = 1024;
  localparam int unsigned PAGE_PAYLOAD = 3992;
  localparam int          HOLD_START   = 6000;
  localparam int          HOLD_CYCLES  = 800;

  logic clk;
  logic rst_n;
  int   error_count;
  int   pending_count;

  pba_req_if req_ch ();
  pba_rsp_if rsp_ch ();

  page_block_allocator_unit #(.NUM_PAGES(NUM_PAGES), .PAGE_PAYLOAD(PAGE_PAYLOAD)) uut (
    .clk(clk), .rst_n(rst_n), .in_req(req_ch.sink), .out_rsp(rsp_ch.source)
  );

  pba_alloc_checker #(.NUM_PAGES(NUM_PAGES), .PAGE_PAYLOAD(PAGE_PAYLOAD)) checker_i (
    .clk(clk), .rst_n(rst_n), .req_mon(req_ch), .rsp_mon(rsp_ch),
    .error_count(error_count), .pending_count(pending_count)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // hard stop
  initial begin
    #60ms;
    $display("Some tests failed");
    $finish;
  end

  // one request, held until accepted; returns at the falling edge after acceptance
  task send_request(input logic kind, input logic [21:0] nbytes, input logic [9:0] page);
    req_ch.valid         <= 1'b1;
    req_ch.kind          <= kind;
    req_ch.request_bytes <= nbytes;
    req_ch.page_index    <= page;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // random gap after a burst, sometimes none
  task sender_pause(inout int burst_left);
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 10);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // receiver: stretches of always ready and random stalls, one long hold-off
  initial begin
    int cyc;
    int stall_mode;
    cyc = 0;
    stall_mode = 0;
    rsp_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 300 == 0) stall_mode = $urandom_range(0, 2);
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES) rsp_ch.ready <= 1'b0;
      else if (stall_mode == 0) rsp_ch.ready <= 1'b1;
      else if (stall_mode == 1) rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      else rsp_ch.ready <= ($urandom_range(0, 3) == 0);
    end
  end

  // stimulus
  initial begin
    int burst_left;
    int pick;
    logic [21:0] nbytes;
    burst_left = 4;
    req_ch.valid         = 1'b0;
    req_ch.kind          = KIND_ALLOC;
    req_ch.request_bytes = '0;
    req_ch.page_index    = '0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // whole memory as one run, then a small request finds no space
    send_request(KIND_ALLOC, 22'd4083816, 10'd0);
    send_request(KIND_ALLOC, 22'd0, 10'd0);
    // free from the middle of the run releases all of it
    send_request(KIND_FREE, 22'd0, 10'd500);
    send_request(KIND_FREE, 22'd0, 10'd500);
    send_request(KIND_FREE, 22'h3FFFFF, 10'd1023);
    // zero byte and rounding
    send_request(KIND_ALLOC, 22'd0, 10'h3FF);
    send_request(KIND_ALLOC, 22'd1, 10'd0);
    send_request(KIND_ALLOC, 22'd4, 10'd0);
    send_request(KIND_ALLOC, 22'd5, 10'd0);
    // largest block: two per page, third goes to a new page
    send_request(KIND_ALLOC, 22'd1996, 10'd0);
    send_request(KIND_ALLOC, 22'd1993, 10'd0);
    send_request(KIND_ALLOC, 22'd1996, 10'd0);
    // smallest multipage, exact page payload, and too long a run
    send_request(KIND_ALLOC, 22'd1997, 10'd0);
    send_request(KIND_ALLOC, 22'd3992, 10'd0);
    send_request(KIND_ALLOC, 22'h3FFFFF, 10'd0);
    // block page count down to release, then a released page is reused
    send_request(KIND_FREE, 22'd0, 10'd0);
    send_request(KIND_FREE, 22'd0, 10'd0);
    send_request(KIND_ALLOC, 22'd8, 10'd0);
    send_request(KIND_FREE, 22'd0, 10'd1);
    send_request(KIND_FREE, 22'd0, 10'd1);
    send_request(KIND_FREE, 22'd0, 10'd1);
    send_request(KIND_FREE, 22'd0, 10'd3);
    send_request(KIND_ALLOC, 22'd2000, 10'd0);

    // random mix
    for (int n = 0; n < 270; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        case ($urandom_range(0, 3))
          0: nbytes = 22'($urandom_range(0, 16));
          1: nbytes = 22'($urandom_range(1, 8) * 100);
          2: nbytes = 22'($urandom_range(1990, 1996));
          default: nbytes = 22'($urandom_range(0, 1996));
        endcase
        send_request(KIND_ALLOC, nbytes, 10'($urandom));
      end else if (pick < 62) begin
        if ($urandom_range(0, 9) == 0) nbytes = 22'($urandom);
        else nbytes = 22'($urandom_range(1997, 6 * PAGE_PAYLOAD - 1));
        send_request(KIND_ALLOC, nbytes, 10'($urandom));
      end else if (pick < 92) begin
        send_request(KIND_FREE, 22'($urandom), 10'($urandom_range(0, 40)));
      end else begin
        send_request(KIND_FREE, 22'($urandom), 10'($urandom));
      end
      sender_pause(burst_left);
    end
    req_ch.valid <= 1'b0;

    // drain, then let the block settle
    wait (pending_count == 0);
    repeat (100) @(posedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/pba_pkg.sv
hdl/pba_if.sv
hdl/pba_datapath.sv
hdl/pba_ctrl.sv
hdl/pba_commit.sv
hdl/page_block_allocator_unit.sv
bench/pba_alloc_checker.sv
bench/tb_top.sv
